FILE: src/min_stk_pkg.sv
package min_stk_pkg;

	localparam int STACK_DEPTH = 64;
	localparam int VALUE_W     = 32;
	// encoded entry 2*value - min needs two extra bits
	localparam int ENTRY_W     = VALUE_W + 2;

	localparam logic FUNC_PUSH = 1'b0;
	localparam logic FUNC_POP  = 1'b1;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_UNDERFLOW = 2'd1,
		STAT_OVERFLOW  = 2'd2
	} status_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_POP  = 1'b1
	} state_t;

endpackage

FILE: src/min_tracking_stack.sv
// min_tracking_stack: signed 32-bit stack that also reports the smallest
// value held.
// Input channel (in_valid/in_ready): func = push or pop, push_value for a push.
// Output channel (out_valid/out_ready): one result per input transaction with
// the decoded top, the minimum, is_empty and a status code (ok, pop on empty,
// push on full). Top and minimum read zero while the stack is empty.
// Timing: the top entry lives in a register, the rest in a one-port-write,
// one-port-read RAM with registered read. A push, a rejected op, or a pop
// that empties the stack gives its result in the next cycle, and the
// next transaction can be taken in that same cycle. A pop that leaves entries
// behind needs the new top out of the RAM: its result is loaded in ST_POP
// after the registered read, and the input is held off while in ST_POP.
// Pushes sustain one transaction per cycle while out_ready stays high.
// The result sits in an output register; a new transaction is accepted while
// that register is empty or being drained in the same cycle, so a stalled
// receiver holds off the input after one pending result.
// Reset: count, minimum and control clear; RAM contents are never cleared
// since only entries below the count are ever read.
module min_tracking_stack #(
	parameter int STACK_DEPTH = min_stk_pkg::STACK_DEPTH
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               func,
	input  logic signed [min_stk_pkg::VALUE_W-1:0] push_value,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [min_stk_pkg::VALUE_W-1:0] top_value,
	output logic signed [min_stk_pkg::VALUE_W-1:0] min_value,
	output logic                               is_empty,
	output logic [1:0]                         status
);

	localparam int VW = min_stk_pkg::VALUE_W;
	localparam int EW = min_stk_pkg::ENTRY_W;
	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int AW = $clog2(STACK_DEPTH);

	// architectural state
	min_stk_pkg::state_t   state_q, state_d;
	logic [CW-1:0]         cnt_q, cnt_d;
	logic signed [VW-1:0]  min_q, min_d;
	logic signed [EW-1:0]  top_q, top_d;   // encoded top entry

	// result register
	logic                  out_valid_q;
	logic signed [VW-1:0]  res_top_q, res_top_d;
	logic signed [VW-1:0]  res_min_q, res_min_d;
	logic                  res_empty_q, res_empty_d;
	min_stk_pkg::status_t  res_status_q, res_status_d;
	logic                  res_load;

	// RAM port signals
	logic                  ram_we, ram_re;
	logic [AW-1:0]         ram_waddr, ram_raddr;
	logic [EW-1:0]         ram_rdata;

	logic                  acc;
	logic                  is_zero, is_full, pop_deep;
	logic [CW-1:0]         cnt_m1, cnt_m2;
	logic signed [EW-1:0]  push_ext, min_ext, enc, rd_ent;
	logic signed [EW:0]    restore_w;
	logic signed [VW-1:0]  restore, cur_top, rd_top;
	logic                  below;

	min_stk_ram #(
		.WIDTH(EW),
		.DEPTH(STACK_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(top_q),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign in_ready = (state_q == min_stk_pkg::ST_IDLE) && (!out_valid_q || out_ready);
	assign acc      = in_valid && in_ready;

	assign is_zero  = (cnt_q == '0);
	assign is_full  = (cnt_q == CW'(STACK_DEPTH));
	assign pop_deep = (cnt_q > CW'(1));
	assign cnt_m1   = cnt_q - CW'(1);
	assign cnt_m2   = cnt_q - CW'(2);
	assign ram_waddr = cnt_m1[AW-1:0];   // old top goes below the new one
	assign ram_raddr = cnt_m2[AW-1:0];   // entry that becomes top after pop

	// push encoding: value below min is stored as 2*value - min
	assign push_ext = EW'(push_value);
	assign min_ext  = EW'(min_q);
	assign below    = (push_value < min_q);
	assign enc      = (push_ext <<< 1) - min_ext;

	// pop decoding: an entry not above min restores min as 2*min - entry
	assign restore_w = ((EW + 1)'(min_q) <<< 1) - (EW + 1)'(top_q);
	assign restore   = (top_q <= min_ext) ? restore_w[VW-1:0] : min_q;

	// decoded top of the current stack and of the entry read back from RAM
	assign cur_top = (top_q > min_ext) ? top_q[VW-1:0] : min_q;
	assign rd_ent  = $signed(ram_rdata);
	assign rd_top  = (rd_ent > min_ext) ? rd_ent[VW-1:0] : min_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			min_stk_pkg::ST_IDLE: begin
				if (acc && func == min_stk_pkg::FUNC_POP && pop_deep) begin
					state_d = min_stk_pkg::ST_POP;
				end
			end
			min_stk_pkg::ST_POP: begin
				state_d = min_stk_pkg::ST_IDLE;
			end
			default: begin
				state_d = min_stk_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cnt_d        = cnt_q;
		min_d        = min_q;
		top_d        = top_q;
		ram_we       = 1'b0;
		ram_re       = 1'b0;
		res_load     = 1'b0;
		res_top_d    = '0;
		res_min_d    = '0;
		res_empty_d  = 1'b1;
		res_status_d = min_stk_pkg::STAT_OK;
		if (state_q == min_stk_pkg::ST_POP) begin
			// min was already restored at acceptance
			res_load    = 1'b1;
			top_d       = rd_ent;
			res_top_d   = rd_top;
			res_min_d   = min_q;
			res_empty_d = 1'b0;
		end else if (acc) begin
			if (func == min_stk_pkg::FUNC_PUSH) begin
				res_load    = 1'b1;
				res_empty_d = 1'b0;
				priority if (is_full) begin
					res_status_d = min_stk_pkg::STAT_OVERFLOW;
					res_top_d    = cur_top;
					res_min_d    = min_q;
				end else if (is_zero) begin
					min_d     = push_value;
					top_d     = push_ext;
					cnt_d     = cnt_q + CW'(1);
					res_top_d = push_value;
					res_min_d = push_value;
				end else begin
					ram_we    = 1'b1;
					top_d     = below ? enc : push_ext;
					min_d     = below ? push_value : min_q;
					cnt_d     = cnt_q + CW'(1);
					res_top_d = push_value;
					res_min_d = below ? push_value : min_q;
				end
			end else begin
				priority if (is_zero) begin
					res_load     = 1'b1;
					res_status_d = min_stk_pkg::STAT_UNDERFLOW;
				end else if (!pop_deep) begin
					// last entry leaves; result reads empty
					res_load = 1'b1;
					min_d    = restore;
					cnt_d    = cnt_m1;
				end else begin
					ram_re = 1'b1;
					min_d  = restore;
					cnt_d  = cnt_m1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= min_stk_pkg::ST_IDLE;
			cnt_q       <= '0;
			min_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			min_q   <= min_d;
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		top_q <= top_d;
		if (res_load) begin
			res_top_q    <= res_top_d;
			res_min_q    <= res_min_d;
			res_empty_q  <= res_empty_d;
			res_status_q <= res_status_d;
		end
	end

	assign out_valid = out_valid_q;
	assign top_value = res_top_q;
	assign min_value = res_min_q;
	assign is_empty  = res_empty_q;
	assign status    = res_status_q;

endmodule

FILE: src/min_stk_ram.sv
module min_stk_ram #(
	parameter int WIDTH = 34,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: src/min_stk_checker.sv
module min_stk_checker (
	input logic                                   clk,
	input logic                                   arst_n,
	input logic                                   out_valid,
	input logic                                   out_ready,
	input logic signed [min_stk_pkg::VALUE_W-1:0] top_value,
	input logic signed [min_stk_pkg::VALUE_W-1:0] min_value,
	input logic                                   is_empty,
	input logic [1:0]                             status
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(top_value) && $stable(min_value)
			&& $stable(is_empty) && $stable(status))
		else $error("result changed while stalled");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_empty |-> top_value == '0 && min_value == '0)
		else $error("empty stack reports nonzero top or min");

	a_underflow_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == min_stk_pkg::STAT_UNDERFLOW |-> is_empty)
		else $error("underflow on a non-empty stack");

	a_overflow_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == min_stk_pkg::STAT_OVERFLOW |-> !is_empty)
		else $error("overflow reported with empty stack");

	a_min_le_top: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_empty |-> min_value <= top_value)
		else $error("minimum above top");

endmodule

bind min_tracking_stack min_stk_checker u_min_stk_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.top_value(top_value),
	.min_value(min_value),
	.is_empty (is_empty),
	.status   (status)
);

FILE: sim/tb_min_tracking_stack.sv
`timescale 1ns / 100ps

// Self-checking bench for the min-tracking stack.
// Stimulus is a list of actions (transactions, idle gaps, drain points) built up
// front. A negedge driver walks the list. A posedge monitor predicts each
// accepted transaction and compares each result against the oldest prediction.
module tb_min_tracking_stack;

	localparam int CLK_HALF     = 10;
	localparam int RESET_CYCLES = 6;
	localparam int RANDOM_OPS   = 500;
	// watchdog bound, with a wide margin over the slowest legal run
	localparam int CYCLE_LIMIT  = 200000;
	// long receiver hold-off, started once after this many results
	localparam int HOLD_AT      = 150;
	localparam int HOLD_CYCLES  = 400;
	// idle stretch at the end, well past the result of the last deep pop
	localparam int TAIL_CYCLES  = 10;

	localparam logic signed [min_stk_pkg::VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;
	localparam logic signed [min_stk_pkg::VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;

	typedef enum logic [1:0] {ACT_OP, ACT_IDLE, ACT_DRAIN} act_kind_t;
	typedef enum logic [1:0] {SEG_FILL, SEG_DRAIN, SEG_CHURN} seg_kind_t;
	typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_MOSTLY, RX_PERIODIC} rx_mode_t;

	typedef struct {
		act_kind_t                              kind;
		logic                                   func;
		logic signed [min_stk_pkg::VALUE_W-1:0] value;
		int                                     cycles;
	} action_t;

	typedef struct {
		logic signed [min_stk_pkg::VALUE_W-1:0] top;
		logic signed [min_stk_pkg::VALUE_W-1:0] minimum;
		logic                                   empty;
		min_stk_pkg::status_t                   stat;
	} stack_result_t;

	// DUT ports; every input is known from time zero
	logic                                   clk        = 1'b0;
	logic                                   arst_n     = 1'b0;
	logic                                   in_valid   = 1'b0;
	logic                                   in_ready;
	logic                                   func       = min_stk_pkg::FUNC_PUSH;
	logic signed [min_stk_pkg::VALUE_W-1:0] push_value = '0;
	logic                                   out_valid;
	logic                                   out_ready  = 1'b0;
	logic signed [min_stk_pkg::VALUE_W-1:0] top_value;
	logic signed [min_stk_pkg::VALUE_W-1:0] min_value;
	logic                                   is_empty;
	logic [1:0]                             status;

	// stimulus list and expected results
	action_t       op_queue[$];
	stack_result_t pending_results[$];

	// shadow stack used for prediction
	logic signed [min_stk_pkg::ENTRY_W-1:0] model_entries [min_stk_pkg::STACK_DEPTH];
	logic signed [min_stk_pkg::VALUE_W-1:0] model_min   = '0;
	int                                     model_count = 0;

	// generator bookkeeping: rough depth, last pushed value, burst shaping
	int                                     gen_depth  = 0;
	int                                     gen_ops    = 0;
	int                                     burst_left = 0;
	bit                                     gaps_on    = 1'b0;
	logic signed [min_stk_pkg::VALUE_W-1:0] gen_last   = '0;

	// driver / receiver / scoreboard state
	logic     in_fire       = 1'b0;
	int       idle_left     = 0;
	int       results_seen  = 0;
	int       fail_count    = 0;
	int       hold_left     = 0;
	bit       hold_done     = 1'b0;
	int       rx_phase_left = 0;
	rx_mode_t rx_mode       = RX_OPEN;
	int       cycle_cnt     = 0;

	min_tracking_stack u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.func      (func),
		.push_value(push_value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.top_value (top_value),
		.min_value (min_value),
		.is_empty  (is_empty),
		.status    (status)
	);

	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	// One push or pop against the shadow stack. Entries are kept 34 bits wide:
	// a push below the current minimum stores 2*value - min and the minimum
	// moves to the value. A pop of an entry at or below the minimum restores
	// the previous minimum as 2*min - entry. Top decodes as max(entry, min).
	function automatic stack_result_t apply_stack_op(logic op,
			logic signed [min_stk_pkg::VALUE_W-1:0] val);
		stack_result_t                          r;
		logic signed [min_stk_pkg::ENTRY_W-1:0] v_ext;
		logic signed [min_stk_pkg::ENTRY_W-1:0] m_ext;
		logic signed [min_stk_pkg::ENTRY_W-1:0] ent;
		logic signed [min_stk_pkg::ENTRY_W-1:0] restored;
		v_ext     = {{(min_stk_pkg::ENTRY_W - min_stk_pkg::VALUE_W)
			{val[min_stk_pkg::VALUE_W-1]}}, val};
		m_ext     = {{(min_stk_pkg::ENTRY_W - min_stk_pkg::VALUE_W)
			{model_min[min_stk_pkg::VALUE_W-1]}}, model_min};
		r.stat    = min_stk_pkg::STAT_OK;
		r.top     = '0;
		r.minimum = '0;
		if (op == min_stk_pkg::FUNC_PUSH) begin
			if (model_count >= min_stk_pkg::STACK_DEPTH) begin
				r.stat = min_stk_pkg::STAT_OVERFLOW;
			end else if (model_count == 0) begin
				// first entry is stored plain and sets the minimum
				model_min        = val;
				model_entries[0] = v_ext;
				model_count      = 1;
			end else begin
				if (val < model_min) begin
					model_entries[model_count] = 2 * v_ext - m_ext;
					model_min                  = val;
				end else begin
					model_entries[model_count] = v_ext;
				end
				model_count++;
			end
		end else if (model_count == 0) begin
			r.stat = min_stk_pkg::STAT_UNDERFLOW;
		end else begin
			ent = model_entries[model_count - 1];
			model_count--;
			if (ent <= m_ext) begin
				restored  = 2 * m_ext - ent;
				model_min = restored[min_stk_pkg::VALUE_W-1:0];
			end
		end
		if (model_count != 0) begin
			ent       = model_entries[model_count - 1];
			m_ext     = {{(min_stk_pkg::ENTRY_W - min_stk_pkg::VALUE_W)
				{model_min[min_stk_pkg::VALUE_W-1]}}, model_min};
			r.top     = (ent > m_ext) ? ent[min_stk_pkg::VALUE_W-1:0] : model_min;
			r.minimum = model_min;
		end
		r.empty = (model_count == 0);
		return r;
	endfunction

	// Append one transaction; with gaps on, bursts of random length are
	// separated by random idle stretches.
	function automatic void queue_op(logic f, logic signed [min_stk_pkg::VALUE_W-1:0] v);
		action_t a;
		if (gaps_on) begin
			if (burst_left == 0) begin
				a.kind     = ACT_IDLE;
				a.func     = min_stk_pkg::FUNC_PUSH;
				a.value    = '0;
				a.cycles   = $urandom_range(1, 8);
				op_queue.push_back(a);
				burst_left = $urandom_range(1, 20);
			end
			burst_left--;
		end
		a.kind   = ACT_OP;
		a.func   = f;
		a.value  = v;
		a.cycles = 0;
		op_queue.push_back(a);
		gen_ops++;
		if (f == min_stk_pkg::FUNC_PUSH) begin
			gen_last = v;
			if (gen_depth < min_stk_pkg::STACK_DEPTH)
				gen_depth++;
		end else if (gen_depth > 0) begin
			gen_depth--;
		end
	endfunction

	// Sender pauses here until every outstanding result is back.
	function automatic void queue_drain();
		action_t a;
		a.kind   = ACT_DRAIN;
		a.func   = min_stk_pkg::FUNC_PUSH;
		a.value  = '0;
		a.cycles = 0;
		op_queue.push_back(a);
	endfunction

	// Push values: extremes, small clustered values (ties with the minimum),
	// descending runs (repeated min encoding), repeats and full-range noise.
	function automatic logic signed [min_stk_pkg::VALUE_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0:       return VAL_MAX;
			1:       return VAL_MIN;
			2:       return $signed($urandom_range(0, 16)) - 8;
			3, 4:    return gen_last - $signed($urandom_range(1, 1000));
			5:       return gen_last;
			default: return $urandom;
		endcase
	endfunction

	// Driver: new payload at the falling edge. An offered transaction is held
	// until the monitor saw it accepted at the previous rising edge.
	always @(negedge clk) begin
		action_t act;
		if (arst_n && !(in_valid && !in_fire)) begin
			if (idle_left != 0) begin
				idle_left <= idle_left - 1;
				in_valid  <= 1'b0;
			end else if (op_queue.size() == 0) begin
				in_valid <= 1'b0;
			end else begin
				act = op_queue[0];
				case (act.kind)
					ACT_OP: begin
						void'(op_queue.pop_front());
						in_valid   <= 1'b1;
						func       <= act.func;
						push_value <= act.value;
					end
					ACT_IDLE: begin
						void'(op_queue.pop_front());
						idle_left <= act.cycles - 1;
						in_valid  <= 1'b0;
					end
					default: begin
						// drain point: wait for the scoreboard to empty
						in_valid <= 1'b0;
						if (pending_results.size() == 0)
							void'(op_queue.pop_front());
					end
				endcase
			end
		end
	end

	// Receiver: stall pattern switches mode at random intervals; one long
	// hold-off fills the output register and backs up the input side.
	always @(negedge clk) begin
		if (hold_left != 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (!hold_done && results_seen >= HOLD_AT) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES - 1;
			out_ready <= 1'b0;
		end else begin
			if (rx_phase_left == 0) begin
				rx_mode       = rx_mode_t'($urandom_range(0, 3));
				rx_phase_left = $urandom_range(16, 96);
			end
			rx_phase_left--;
			case (rx_mode)
				RX_OPEN:   out_ready <= 1'b1;
				RX_COIN:   out_ready <= $urandom_range(0, 1);
				RX_MOSTLY: out_ready <= ($urandom_range(0, 7) != 0);
				default:   out_ready <= ((rx_phase_left % 3) != 0);
			endcase
		end
	end

	// Monitor and scoreboard at the rising edge: check the result first, then
	// predict the transaction accepted on this same edge.
	always @(posedge clk) begin
		stack_result_t exp_r;
		if (arst_n) begin
			in_fire <= in_valid && in_ready;
			if (out_valid && out_ready) begin
				results_seen++;
				if (pending_results.size() == 0) begin
					$error("result with no transaction outstanding");
					fail_count++;
				end else begin
					exp_r = pending_results.pop_front();
					if (top_value !== exp_r.top) begin
						$error("top_value: expected %0d, got %0d", exp_r.top, top_value);
						fail_count++;
					end
					if (min_value !== exp_r.minimum) begin
						$error("min_value: expected %0d, got %0d", exp_r.minimum, min_value);
						fail_count++;
					end
					if (is_empty !== exp_r.empty) begin
						$error("is_empty: expected %0b, got %0b", exp_r.empty, is_empty);
						fail_count++;
					end
					if (status !== exp_r.stat) begin
						$error("status: expected %0d, got %0d", exp_r.stat, status);
						fail_count++;
					end
				end
			end
			if (in_valid && in_ready)
				pending_results.push_back(apply_stack_op(func, push_value));
		end
	end

	// Watchdog
	initial begin
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		seg_kind_t seg;
		int        pick;

		// directed: extremes, min encoding at the range limits, ties with the
		// minimum, pop down to empty, pop on empty, push onto an empty stack
		gaps_on = 1'b0;
		queue_op(min_stk_pkg::FUNC_PUSH, VAL_MAX);
		queue_op(min_stk_pkg::FUNC_PUSH, VAL_MIN);
		queue_op(min_stk_pkg::FUNC_PUSH, VAL_MIN);
		queue_op(min_stk_pkg::FUNC_PUSH, VAL_MAX);
		queue_op(min_stk_pkg::FUNC_PUSH, '0);
		repeat (6) queue_op(min_stk_pkg::FUNC_POP, $urandom);
		queue_op(min_stk_pkg::FUNC_PUSH, -32'sd5);
		queue_op(min_stk_pkg::FUNC_PUSH, -32'sd5);
		queue_op(min_stk_pkg::FUNC_PUSH, -32'sd7);
		queue_op(min_stk_pkg::FUNC_PUSH, -32'sd6);
		queue_op(min_stk_pkg::FUNC_PUSH, -32'sd7);
		repeat (5) queue_op(min_stk_pkg::FUNC_POP, $urandom);
		queue_drain();

		// random: fill to full plus overflow, drain to empty plus underflow,
		// and mixed stretches; starts with a fill so overflow is always hit
		gen_ops = 0;
		seg     = SEG_FILL;
		while (gen_ops < RANDOM_OPS) begin
			gaps_on = ($urandom_range(0, 3) != 0);
			case (seg)
				SEG_FILL: begin
					while (gen_depth < min_stk_pkg::STACK_DEPTH)
						queue_op(min_stk_pkg::FUNC_PUSH, pick_value());
					repeat ($urandom_range(1, 3))
						queue_op(min_stk_pkg::FUNC_PUSH, pick_value());
				end
				SEG_DRAIN: begin
					while (gen_depth > 0)
						queue_op(min_stk_pkg::FUNC_POP, $urandom);
					repeat ($urandom_range(1, 2)) queue_op(min_stk_pkg::FUNC_POP, $urandom);
				end
				default: begin
					repeat ($urandom_range(10, 40))
						queue_op(($urandom_range(0, 9) < 6) ? min_stk_pkg::FUNC_PUSH
							: min_stk_pkg::FUNC_POP, pick_value());
				end
			endcase
			if ($urandom_range(0, 7) == 0)
				queue_drain();
			pick = $urandom_range(0, 9);
			seg  = (pick < 2) ? SEG_FILL : (pick < 5) ? SEG_DRAIN : SEG_CHURN;
		end

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (op_queue.size() != 0 || in_valid || pending_results.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);

		if (pending_results.size() != 0) begin
			$error("%0d expected results never arrived", pending_results.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

FILE: sim.f
src/min_stk_pkg.sv
src/min_stk_ram.sv
src/min_tracking_stack.sv
src/min_stk_checker.sv
sim/tb_min_tracking_stack.sv
